// File: hdl/att_pkg.sv
// Package for the aircraft track table: command and status codes,
// configuration register indexes, field widths and the configuration struct.
// Has no dependencies.
package att_pkg;

	localparam int ADDR_W  = 24;
	localparam int DIST_W  = 16;
	localparam int TYPE_W  = 8;
	localparam int TIME_W  = 32;
	localparam int EXP_W   = 16;
	localparam int SLOT_W  = 5;
	localparam int CMD_W   = 3;
	localparam int STAT_W  = 3;
	localparam int CIDX_W  = 2;
	localparam int CDATA_W = 24;
	localparam int BKT_W   = 8;

	typedef enum logic [CMD_W-1:0] {
		CMD_IDENT = 3'd0,
		CMD_POS   = 3'd1,
		CMD_VEL   = 3'd2,
		CMD_MODES = 3'd3,
		CMD_SWEEP = 3'd4
	} att_cmd_t;

	typedef enum logic [STAT_W-1:0] {
		ST_IGNORED  = 3'd0,
		ST_FOUND    = 3'd1,
		ST_NEW      = 3'd2,
		ST_REPLACED = 3'd3,
		ST_EXPIRED  = 3'd4,
		ST_REFRESH  = 3'd5,
		ST_EMPTY    = 3'd6,
		ST_UNPOS    = 3'd7
	} att_status_t;

	localparam logic [CIDX_W-1:0] CFG_TYPE_FILTER = 2'd0;
	localparam logic [CIDX_W-1:0] CFG_FOLLOWED    = 2'd1;
	localparam logic [CIDX_W-1:0] CFG_EXPIRY      = 2'd2;

	localparam logic [TYPE_W-1:0] TF_OFF        = 8'd0;
	localparam logic [TYPE_W-1:0] TF_HEAVY_ONLY = 8'd254;
	localparam logic [TYPE_W-1:0] TF_NOT_HEAVY  = 8'd255;
	localparam logic [TYPE_W-1:0] HEAVY_LO      = 8'd10;
	localparam logic [TYPE_W-1:0] HEAVY_HI      = 8'd13;
	localparam logic [EXP_W-1:0]  EXPIRY_RESET  = 16'd30;
	localparam int                FREE_SHIFT    = 5;

	typedef struct packed {
		logic [TYPE_W-1:0] type_filter;
		logic [ADDR_W-1:0] followed_address;
		logic [EXP_W-1:0]  expiry_time;
	} att_cfg_t;

endpackage

// File: hdl/att_if.sv
// Handshake interfaces of the aircraft track table: message, result and
// configuration write channels.
// Depends on att_pkg.
interface att_msg_if;
	logic                         valid;
	logic                         ready;
	logic [att_pkg::CMD_W-1:0]    command;
	logic [att_pkg::ADDR_W-1:0]   address;
	logic [att_pkg::DIST_W-1:0]   distance;
	logic [att_pkg::TYPE_W-1:0]   category;
	logic                         has_latitude;
	logic [att_pkg::TIME_W-1:0]   now;
	modport source (output valid, command, address, distance, category, has_latitude,
		now, input ready);
	modport sink (input valid, command, address, distance, category, has_latitude,
		now, output ready);
endinterface

interface att_res_if;
	logic                         valid;
	logic                         ready;
	logic [att_pkg::SLOT_W-1:0]   slot;
	logic [att_pkg::STAT_W-1:0]   status;
	logic                         visible;
	logic [att_pkg::SLOT_W-1:0]   tracked_count;
	logic [att_pkg::SLOT_W-1:0]   closest_slot;
	modport source (output valid, slot, status, visible, tracked_count, closest_slot,
		input ready);
	modport sink (input valid, slot, status, visible, tracked_count, closest_slot,
		output ready);
endinterface

interface att_cfg_if;
	logic                         valid;
	logic                         ready;
	logic [att_pkg::CIDX_W-1:0]   index;
	logic [att_pkg::CDATA_W-1:0]  data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// File: hdl/att_bucket_ram.sv
// Bucket head memory: 256 chain heads, one write and one registered read
// port, with a valid bit per entry so that reset needs no clearing pass.
// Depends on att_pkg.
module att_bucket_ram #(
	parameter int DATA_W = 5
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [att_pkg::BKT_W-1:0]    rd_addr,
	output logic [DATA_W-1:0]            rd_data,
	input  logic                         wr_en,
	input  logic [att_pkg::BKT_W-1:0]    wr_addr,
	input  logic [DATA_W-1:0]            wr_data
);
	import att_pkg::*;

	localparam int DEPTH = 1 << BKT_W;

	logic [DATA_W-1:0] mem [DEPTH];
	logic [DEPTH-1:0]  valid_q;
	logic [DATA_W-1:0] rd_data_q;

	// An unwritten head reads as its reset value: bucket 0 holds slot 1.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= '0;
			rd_data_q <= '0;
		end else begin
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (valid_q[rd_addr]) begin
				rd_data_q <= mem[rd_addr];
			end else begin
				rd_data_q <= DATA_W'(rd_addr == '0);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	assign rd_data = rd_data_q;

endmodule

// File: hdl/att_seq.sv
// Sequencer of the aircraft track table: walks bucket chains one link per
// cycle, unlinks and links slots, ages entries and holds the result register.
// Depends on att_pkg and att_bucket_ram (connected by the top level).
module att_seq #(
	parameter int TABLE_DEPTH = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  att_pkg::att_cfg_t                 cfg,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [att_pkg::CMD_W-1:0]         in_command,
	input  logic [att_pkg::ADDR_W-1:0]        in_address,
	input  logic [att_pkg::DIST_W-1:0]        in_distance,
	input  logic [att_pkg::TYPE_W-1:0]        in_type,
	input  logic                              in_latitude,
	input  logic [att_pkg::TIME_W-1:0]        in_now,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [att_pkg::SLOT_W-1:0]        out_slot,
	output logic [att_pkg::STAT_W-1:0]        out_status,
	output logic                              out_visible,
	output logic [att_pkg::SLOT_W-1:0]        out_tracked,
	output logic [att_pkg::SLOT_W-1:0]        out_closest,
	output logic [att_pkg::BKT_W-1:0]         ram_rd_addr,
	input  logic [$clog2(TABLE_DEPTH+1)-1:0]  ram_rd_data,
	output logic                              ram_wr_en,
	output logic [att_pkg::BKT_W-1:0]         ram_wr_addr,
	output logic [$clog2(TABLE_DEPTH+1)-1:0]  ram_wr_data
);
	import att_pkg::*;

	localparam int SW = $clog2(TABLE_DEPTH + 1);
	localparam int IW = $clog2(TABLE_DEPTH);
	localparam int LIM_W = EXP_W + FREE_SHIFT;
	localparam logic [SW-1:0] DEPTH_S = SW'(TABLE_DEPTH);
	localparam logic [IW-1:0] LAST_I  = IW'(TABLE_DEPTH - 1);

	typedef enum logic [3:0] {
		S_IDLE, S_LK_RD, S_LK_HEAD, S_LK_STEP, S_UL_RD, S_UL_HEAD, S_UL_STEP,
		S_LN_RD, S_LN_WR, S_APPLY, S_SW_START, S_SW_EVAL, S_FIN
	} state_t;

	typedef enum logic {PH_MAIN, PH_FREE} phase_t;

	state_t            state_q;
	phase_t            phase_q;
	att_cmd_t          cmd_q;
	att_status_t       status_q;
	logic [ADDR_W-1:0] addr_q;
	logic [ADDR_W-1:0] key_q;
	logic [DIST_W-1:0] dist_q;
	logic [TYPE_W-1:0] atype_q;
	logic              lat_q;
	logic [TIME_W-1:0] now_q;
	logic [SW-1:0]     cur_q;
	logic [SW-1:0]     cnt_q;
	logic [SW-1:0]     s_q;
	logic [BKT_W-1:0]  b_q;
	logic [SW-1:0]     snext_q;

	logic [ADDR_W-1:0] eaddr_q [TABLE_DEPTH];
	logic [SW-1:0]     enext_q [TABLE_DEPTH];
	logic [TIME_W-1:0] etime_q [TABLE_DEPTH];
	logic [DIST_W-1:0] edist_q [TABLE_DEPTH];
	logic [TYPE_W-1:0] etype_q [TABLE_DEPTH];
	logic              epos_q  [TABLE_DEPTH];

	logic [SW-1:0]     occ_q;
	logic [IW-1:0]     sc_q;
	logic [DIST_W-1:0] far_dist_q;
	logic [ADDR_W-1:0] far_addr_q;
	logic [SW-1:0]     far_slot_q;
	logic [DIST_W-1:0] close_dist_q;
	logic [ADDR_W-1:0] close_addr_q;
	logic [SW-1:0]     close_slot_q;

	logic              ov_q;
	logic [SLOT_W-1:0] o_slot_q;
	logic [STAT_W-1:0] o_status_q;
	logic              o_vis_q;
	logic [SLOT_W-1:0] o_tracked_q;
	logic [SLOT_W-1:0] o_closest_q;

	logic [IW-1:0]     ridx;
	logic [ADDR_W-1:0] r_addr;
	logic [SW-1:0]     r_next;
	logic [TIME_W-1:0] r_time;
	logic [DIST_W-1:0] r_dist;
	logic [ADDR_W-1:0] new_addr;
	logic              cur_ok;
	logic              cnt_done;
	logic [LIM_W-1:0]  limit;
	logic              expired;
	logic [SW-1:0]     occ_dec;
	logic [SW-1:0]     occ_link;
	logic [IW-1:0]     sc_next;

	function automatic logic filter_pass(input logic [TYPE_W-1:0] t,
		input logic [TYPE_W-1:0] f);
		logic heavy;
		logic pass;
		heavy = (t >= HEAVY_LO) && (t <= HEAVY_HI);
		if (f == TF_OFF) begin
			pass = 1'b1;
		end else if (f == TF_HEAVY_ONLY) begin
			pass = (t != '0) && heavy;
		end else if (f == TF_NOT_HEAVY) begin
			pass = (t != '0) && !heavy;
		end else begin
			pass = (t == f);
		end
		return pass;
	endfunction

	always_comb begin
		ridx     = IW'(cur_q - SW'(1));
		r_addr   = eaddr_q[ridx];
		r_next   = enext_q[ridx];
		r_time   = etime_q[ridx];
		r_dist   = edist_q[ridx];
		new_addr = (cmd_q == CMD_SWEEP) ? '0 : addr_q;
		cur_ok   = (cur_q != '0) && (cur_q <= DEPTH_S);
		cnt_done = (cnt_q >= DEPTH_S);
		limit    = (occ_q < DEPTH_S) ? {cfg.expiry_time, FREE_SHIFT'(0)} : LIM_W'(cfg.expiry_time);
		expired  = {1'b0, now_q} > ({1'b0, r_time} + (TIME_W+1)'(limit));
		sc_next  = (sc_q == LAST_I) ? '0 : sc_q + IW'(1);
		occ_dec  = occ_q;
		if (new_addr == '0 && occ_q != '0) begin
			occ_dec = occ_q - SW'(1);
		end
		occ_link = occ_dec;
		if (r_addr == '0 && occ_dec < DEPTH_S) begin
			occ_link = occ_dec + SW'(1);
		end
	end

	always_comb begin
		ram_rd_addr = key_q[BKT_W-1:0];
		ram_wr_en   = 1'b0;
		ram_wr_addr = b_q;
		ram_wr_data = snext_q;
		unique case (state_q)
			S_UL_RD: ram_rd_addr = r_addr[BKT_W-1:0];
			S_LN_RD: ram_rd_addr = new_addr[BKT_W-1:0];
			S_UL_HEAD: ram_wr_en = (ram_rd_data == s_q);
			S_LN_WR: begin
				ram_wr_en   = 1'b1;
				ram_wr_addr = new_addr[BKT_W-1:0];
				ram_wr_data = s_q;
			end
			default: ram_rd_addr = key_q[BKT_W-1:0];
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			phase_q      <= PH_MAIN;
			cmd_q        <= CMD_IDENT;
			status_q     <= ST_IGNORED;
			addr_q       <= '0;
			key_q        <= '0;
			dist_q       <= '0;
			atype_q      <= '0;
			lat_q        <= 1'b0;
			now_q        <= '0;
			cur_q        <= '0;
			cnt_q        <= '0;
			s_q          <= '0;
			b_q          <= '0;
			snext_q      <= '0;
			for (int k = 0; k < TABLE_DEPTH; k++) begin
				eaddr_q[k] <= '0;
				enext_q[k] <= (k + 1 < TABLE_DEPTH) ? SW'(k + 2) : '0;
				etime_q[k] <= '0;
				edist_q[k] <= '0;
				etype_q[k] <= '0;
				epos_q[k]  <= 1'b0;
			end
			occ_q        <= '0;
			sc_q         <= '0;
			far_dist_q   <= '0;
			far_addr_q   <= '0;
			far_slot_q   <= '0;
			close_dist_q <= '1;
			close_addr_q <= '0;
			close_slot_q <= '0;
			ov_q         <= 1'b0;
			o_slot_q     <= '0;
			o_status_q   <= '0;
			o_vis_q      <= 1'b0;
			o_tracked_q  <= '0;
			o_closest_q  <= '0;
		end else begin
			if (ov_q && out_ready && state_q != S_FIN) begin
				ov_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						cmd_q   <= att_cmd_t'(in_command);
						addr_q  <= in_address;
						key_q   <= in_address;
						dist_q  <= in_distance;
						atype_q <= in_type;
						lat_q   <= in_latitude;
						now_q   <= in_now;
						phase_q <= PH_MAIN;
						if (in_command == CMD_SWEEP) begin
							state_q <= S_SW_START;
						end else if (in_command <= CMD_MODES && in_address != '0) begin
							state_q <= S_LK_RD;
						end else begin
							cur_q    <= '0;
							status_q <= ST_IGNORED;
							state_q  <= S_FIN;
						end
					end
				end
				S_LK_RD: state_q <= S_LK_HEAD;
				S_LK_HEAD: begin
					cur_q   <= ram_rd_data;
					cnt_q   <= '0;
					state_q <= S_LK_STEP;
				end
				S_LK_STEP: begin
					if (!cnt_done && cur_ok && r_addr == key_q) begin
						if (phase_q == PH_MAIN) begin
							status_q <= ST_FOUND;
							if (cmd_q == CMD_IDENT) begin
								etype_q[ridx] <= atype_q;
							end
							if (cmd_q == CMD_POS || cmd_q == CMD_MODES) begin
								state_q <= S_APPLY;
							end else begin
								state_q <= S_FIN;
							end
						end else begin
							s_q      <= cur_q;
							status_q <= ST_NEW;
							state_q  <= S_UL_RD;
						end
					end else if (!cnt_done && cur_ok) begin
						cur_q <= r_next;
						cnt_q <= cnt_q + SW'(1);
					end else if (phase_q == PH_MAIN) begin
						if (cmd_q == CMD_POS || cmd_q == CMD_MODES) begin
							key_q   <= '0;
							phase_q <= PH_FREE;
							state_q <= S_LK_RD;
						end else begin
							cur_q    <= '0;
							status_q <= ST_IGNORED;
							state_q  <= S_FIN;
						end
					end else begin
						occ_q <= DEPTH_S;
						if (dist_q < far_dist_q && far_slot_q != '0 && far_slot_q <= DEPTH_S) begin
							s_q        <= far_slot_q;
							cur_q      <= far_slot_q;
							far_dist_q <= '0;
							far_addr_q <= '0;
							far_slot_q <= '0;
							status_q   <= ST_REPLACED;
							state_q    <= S_UL_RD;
						end else begin
							cur_q    <= '0;
							status_q <= ST_IGNORED;
							state_q  <= S_FIN;
						end
					end
				end
				S_UL_RD: begin
					b_q     <= r_addr[BKT_W-1:0];
					snext_q <= r_next;
					state_q <= S_UL_HEAD;
				end
				S_UL_HEAD: begin
					if (ram_rd_data == s_q) begin
						state_q <= S_LN_RD;
					end else begin
						cur_q   <= ram_rd_data;
						cnt_q   <= '0;
						state_q <= S_UL_STEP;
					end
				end
				S_UL_STEP: begin
					if (!cnt_done && cur_ok) begin
						if (r_next == s_q) begin
							enext_q[ridx] <= snext_q;
							cur_q         <= s_q;
							state_q       <= S_LN_RD;
						end else begin
							cur_q <= r_next;
							cnt_q <= cnt_q + SW'(1);
						end
					end else begin
						cur_q   <= s_q;
						state_q <= S_LN_RD;
					end
				end
				S_LN_RD: state_q <= S_LN_WR;
				S_LN_WR: begin
					if (new_addr == '0) begin
						if (r_addr == far_addr_q) begin
							far_dist_q <= '0;
							far_addr_q <= '0;
							far_slot_q <= '0;
						end
						if (r_addr == close_addr_q) begin
							close_dist_q <= '1;
							close_addr_q <= '0;
							close_slot_q <= '0;
						end
					end
					occ_q         <= occ_link;
					eaddr_q[ridx] <= new_addr;
					enext_q[ridx] <= ram_rd_data;
					etime_q[ridx] <= '0;
					edist_q[ridx] <= '0;
					etype_q[ridx] <= '0;
					epos_q[ridx]  <= 1'b0;
					state_q       <= (cmd_q == CMD_SWEEP) ? S_FIN : S_APPLY;
				end
				S_APPLY: begin
					if (cmd_q == CMD_POS) begin
						epos_q[ridx]  <= lat_q;
						edist_q[ridx] <= dist_q;
						etime_q[ridx] <= filter_pass(etype_q[ridx], cfg.type_filter) ? now_q : '0;
					end else if (!epos_q[ridx]) begin
						etime_q[ridx] <= now_q;
					end
					state_q <= S_FIN;
				end
				S_SW_START: begin
					sc_q    <= sc_next;
					cur_q   <= SW'(sc_next) + SW'(1);
					state_q <= S_SW_EVAL;
				end
				S_SW_EVAL: begin
					if (r_addr == '0) begin
						status_q <= ST_EMPTY;
						state_q  <= S_FIN;
					end else if (expired) begin
						s_q      <= cur_q;
						status_q <= ST_EXPIRED;
						state_q  <= S_UL_RD;
					end else if (r_time == '0) begin
						status_q <= ST_UNPOS;
						state_q  <= S_FIN;
					end else begin
						if (r_dist > far_dist_q && r_addr != cfg.followed_address) begin
							far_dist_q <= r_dist;
							far_addr_q <= r_addr;
							far_slot_q <= cur_q;
						end else if (r_addr == far_addr_q && r_dist < far_dist_q) begin
							far_dist_q <= r_dist;
						end
						if (r_dist != '0 && r_dist < close_dist_q) begin
							close_dist_q <= r_dist;
							close_addr_q <= r_addr;
							close_slot_q <= cur_q;
						end else if (r_addr == close_addr_q && r_dist > close_dist_q) begin
							close_dist_q <= r_dist;
						end
						status_q <= ST_REFRESH;
						state_q  <= S_FIN;
					end
				end
				S_FIN: begin
					if (!ov_q || out_ready) begin
						ov_q        <= 1'b1;
						o_slot_q    <= SLOT_W'(cur_q);
						o_status_q  <= status_q;
						o_vis_q     <= cur_ok && (r_time != '0);
						o_tracked_q <= SLOT_W'(occ_q);
						o_closest_q <= (close_addr_q != '0) ? SLOT_W'(close_slot_q) : '0;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_ready    = (state_q == S_IDLE);
	assign out_valid   = ov_q;
	assign out_slot    = o_slot_q;
	assign out_status  = o_status_q;
	assign out_visible = o_vis_q;
	assign out_tracked = o_tracked_q;
	assign out_closest = o_closest_q;

endmodule

// File: hdl/aircraft_track_table_unit.sv
// Top level of the aircraft track table: configuration registers, the
// bucket head memory and the chain-walking sequencer.
// Depends on att_pkg, att_if, att_bucket_ram and att_seq.
//
// One message is taken at a time; msg.ready stays low until its work is done.
// A message that is ignored at once goes straight to the result step; the
// longest work is a new aircraft that misses on its own chain and
// replaces the farthest one, which also walks the old chain of that slot. The
// chain walks go one link per cycle through the entry registers, and each
// walk starts with a registered read of the bucket head memory. A sweep tick
// checks one slot and, when it expires an entry, also walks its chain to unlink
// it. A result that still waits holds the last step until it is taken.
// The result register lets the next message enter while a result waits. Reset
// needs no clearing pass: the bucket heads carry valid bits.
module aircraft_track_table_unit #(
	parameter int TABLE_DEPTH = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	att_msg_if.sink   msg,
	att_res_if.source result,
	att_cfg_if.sink   cfg
);
	import att_pkg::*;

	localparam int SW = $clog2(TABLE_DEPTH + 1);

	att_cfg_t         cfg_q;
	logic [BKT_W-1:0] ram_rd_addr;
	logic [SW-1:0]    ram_rd_data;
	logic             ram_wr_en;
	logic [BKT_W-1:0] ram_wr_addr;
	logic [SW-1:0]    ram_wr_data;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.type_filter      <= TF_OFF;
			cfg_q.followed_address <= '0;
			cfg_q.expiry_time      <= EXPIRY_RESET;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				CFG_TYPE_FILTER: cfg_q.type_filter      <= cfg.data[TYPE_W-1:0];
				CFG_FOLLOWED:    cfg_q.followed_address <= cfg.data[ADDR_W-1:0];
				CFG_EXPIRY:      cfg_q.expiry_time      <= cfg.data[EXP_W-1:0];
				default:         cfg_q                  <= cfg_q;
			endcase
		end
	end

	att_bucket_ram #(
		.DATA_W(SW)
	) u_ram (
		.clk    (clk),
		.arst_n (arst_n),
		.rd_addr(ram_rd_addr),
		.rd_data(ram_rd_data),
		.wr_en  (ram_wr_en),
		.wr_addr(ram_wr_addr),
		.wr_data(ram_wr_data)
	);

	att_seq #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.in_valid   (msg.valid),
		.in_ready   (msg.ready),
		.in_command (msg.command),
		.in_address (msg.address),
		.in_distance(msg.distance),
		.in_type    (msg.category),
		.in_latitude(msg.has_latitude),
		.in_now     (msg.now),
		.out_valid  (result.valid),
		.out_ready  (result.ready),
		.out_slot   (result.slot),
		.out_status (result.status),
		.out_visible(result.visible),
		.out_tracked(result.tracked_count),
		.out_closest(result.closest_slot),
		.ram_rd_addr(ram_rd_addr),
		.ram_rd_data(ram_rd_data),
		.ram_wr_en  (ram_wr_en),
		.ram_wr_addr(ram_wr_addr),
		.ram_wr_data(ram_wr_data)
	);

endmodule

// File: hdl/att_checker.sv
// Port-level checks of the aircraft track table and their binding.
// Depends on att_pkg and aircraft_track_table_unit.
module att_checker #(
	parameter int TABLE_DEPTH = 16
) (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       msg_valid,
	input logic                       msg_ready,
	input logic                       res_valid,
	input logic                       res_ready,
	input logic [att_pkg::SLOT_W-1:0] res_slot,
	input logic [att_pkg::STAT_W-1:0] res_status,
	input logic                       res_visible,
	input logic [att_pkg::SLOT_W-1:0] res_tracked
);
	import att_pkg::*;

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_slot) && $stable(res_status))
		else $error("Result changed before its transfer.");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		msg_valid && msg_ready |=> !msg_ready)
		else $error("Message accepted while the previous one is still at work.");

	a_ignored: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> ((res_status == ST_IGNORED) == (res_slot == '0)))
		else $error("Slot and ignored status disagree.");

	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_status == ST_EMPTY |-> !res_visible)
		else $error("Empty slot reported visible.");

	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> int'(res_tracked) <= TABLE_DEPTH)
		else $error("Tracked count beyond table depth.");

endmodule

bind aircraft_track_table_unit att_checker #(
	.TABLE_DEPTH(TABLE_DEPTH)
) u_att_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.msg_valid  (msg.valid),
	.msg_ready  (msg.ready),
	.res_valid  (result.valid),
	.res_ready  (result.ready),
	.res_slot   (result.slot),
	.res_status (result.status),
	.res_visible(result.visible),
	.res_tracked(result.tracked_count)
);
